// File: sv/rvid_pkg.sv
// Shared types, codes and the pattern table for the RV32IMA instruction decoder.
// No dependencies; every other file refers to this package by scoped names.

package rvid_pkg;

  localparam int unsigned EntryCount = 72;

  // Immediate layout of a table entry.
  typedef enum logic [2:0] {
    LAY_R,
    LAY_I,
    LAY_S,
    LAY_B,
    LAY_U,
    LAY_J
  } lay_e;

  // Operand format codes, as seen on the operand_format port.
  typedef enum logic [3:0] {
    FMT_NONE = 4'd0,
    FMT_RRR  = 4'd1,
    FMT_RRI  = 4'd2,
    FMT_RRS  = 4'd3,
    FMT_RR   = 4'd4,
    FMT_RI   = 4'd5,
    FMT_RT   = 4'd6,
    FMT_RRT  = 4'd7,
    FMT_RBI  = 4'd8,
    FMT_MO   = 4'd9,
    FMT_AMO2 = 4'd10,
    FMT_AMO3 = 4'd11,
    FMT_CSRR = 4'd12,
    FMT_CSRI = 4'd13
  } fmt_e;

  // Mnemonic indexes, as seen on the mnemonic port.
  typedef enum logic [6:0] {
    MN_ADD, MN_ADDI, MN_SUB, MN_LUI, MN_AUIPC, MN_XOR, MN_XORI, MN_OR, MN_ORI,
    MN_AND, MN_ANDI, MN_SLT, MN_SLTI, MN_SLTU, MN_SLTIU, MN_SLL, MN_SLLI,
    MN_SRL, MN_SRLI, MN_SRA, MN_SRAI, MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU,
    MN_BGEU, MN_JAL, MN_JALR, MN_LB, MN_LH, MN_LW, MN_LBU, MN_LHU, MN_SB,
    MN_SH, MN_SW, MN_FENCE, MN_FENCE_I, MN_CSRRW, MN_CSRRS, MN_CSRRC,
    MN_CSRRWI, MN_CSRRSI, MN_CSRRCI, MN_MUL, MN_MULH, MN_MULHSU, MN_MULHU,
    MN_DIV, MN_DIVU, MN_REM, MN_REMU, MN_LR_W, MN_SC_W, MN_AMOSWAP_W,
    MN_AMOADD_W, MN_AMOXOR_W, MN_AMOAND_W, MN_AMOOR_W, MN_AMOMIN_W,
    MN_AMOMAX_W, MN_AMOMINU_W, MN_AMOMAXU_W, MN_ECALL, MN_EBREAK, MN_SRET,
    MN_MRET, MN_WFI, MN_SFENCE_VMA, MN_NOP, MN_UNIMP
  } mnem_e;

  // Major opcodes.
  localparam logic [6:0] OpReg    = 7'b0110011;
  localparam logic [6:0] OpImm    = 7'b0010011;
  localparam logic [6:0] OpLui    = 7'b0110111;
  localparam logic [6:0] OpAuipc  = 7'b0010111;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpJalr   = 7'b1100111;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpSystem = 7'b1110011;
  localparam logic [6:0] OpAmo    = 7'b0101111;

  localparam logic [6:0] F7Base = 7'b0000000;
  localparam logic [6:0] F7Alt  = 7'b0100000;
  localparam logic [6:0] F7Mul  = 7'b0000001;

  // Decode result of the pattern match.
  typedef struct packed {
    mnem_e mnem;
    lay_e  lay;
    fmt_e  fmt;
  } decode_t;

  typedef struct packed {
    logic [31:0] pat_mask;
    logic [31:0] pat_bits;
    decode_t     dec;
  } entry_t;

  function automatic entry_t mk(mnem_e mn, logic [31:0] msk, logic [31:0] val,
                                lay_e lay, fmt_e fmt);
    entry_t e;
    e.pat_mask = msk;
    e.pat_bits = val;
    e.dec.mnem = mn;
    e.dec.lay  = lay;
    e.dec.fmt  = fmt;
    return e;
  endfunction

  function automatic entry_t r_ent(mnem_e mn, logic [6:0] f7, logic [2:0] f3,
                                   logic [6:0] op, fmt_e fmt);
    return mk(mn, 32'hFE00707F, {f7, 10'b0, f3, 5'b0, op}, LAY_R, fmt);
  endfunction

  function automatic entry_t i_ent(mnem_e mn, logic [2:0] f3, logic [6:0] op,
                                   lay_e lay, fmt_e fmt);
    return mk(mn, 32'h0000707F, {17'b0, f3, 5'b0, op}, lay, fmt);
  endfunction

  function automatic entry_t u_ent(mnem_e mn, logic [6:0] op, lay_e lay, fmt_e fmt);
    return mk(mn, 32'h0000007F, {25'b0, op}, lay, fmt);
  endfunction

  function automatic entry_t a_ent(mnem_e mn, logic [4:0] f5);
    return mk(mn, 32'hF800707F, {f5, 12'b0, 3'b010, 5'b0, OpAmo}, LAY_R, FMT_AMO3);
  endfunction

  // Patterns ranked by number of fixed bits, most specific first; within one
  // rank in mnemonic order. The first entry that hits wins; unimp hits always.
  localparam entry_t DecodeTable [EntryCount] = '{
    // fully or mostly fixed words
    mk(MN_FENCE_I,    32'hFFFFFFFF, 32'h0000100F, LAY_I, FMT_NONE),
    mk(MN_ECALL,      32'hFFFFFFFF, 32'h00000073, LAY_I, FMT_NONE),
    mk(MN_EBREAK,     32'hFFFFFFFF, 32'h00100073, LAY_I, FMT_NONE),
    mk(MN_SRET,       32'hFFFFFFFF, 32'h10200073, LAY_R, FMT_NONE),
    mk(MN_MRET,       32'hFFFFFFFF, 32'h30200073, LAY_R, FMT_NONE),
    mk(MN_WFI,        32'hFFFFFFFF, 32'h10500073, LAY_R, FMT_NONE),
    mk(MN_NOP,        32'hFFFFFFFF, 32'h00000013, LAY_I, FMT_NONE),
    mk(MN_FENCE,      32'hF00FFFFF, 32'h0000000F, LAY_I, FMT_MO),
    mk(MN_SFENCE_VMA, 32'hFE007FFF, 32'h12000073, LAY_R, FMT_RR),
    mk(MN_LR_W,       32'hF9F0707F, 32'h1000202F, LAY_R, FMT_AMO2),
    // register-register and shift-immediate
    r_ent(MN_ADD,    F7Base, 3'b000, OpReg, FMT_RRR),
    r_ent(MN_SUB,    F7Alt,  3'b000, OpReg, FMT_RRR),
    r_ent(MN_XOR,    F7Base, 3'b100, OpReg, FMT_RRR),
    r_ent(MN_OR,     F7Base, 3'b110, OpReg, FMT_RRR),
    r_ent(MN_AND,    F7Base, 3'b111, OpReg, FMT_RRR),
    r_ent(MN_SLT,    F7Base, 3'b010, OpReg, FMT_RRR),
    r_ent(MN_SLTU,   F7Base, 3'b011, OpReg, FMT_RRR),
    r_ent(MN_SLL,    F7Base, 3'b001, OpReg, FMT_RRR),
    r_ent(MN_SLLI,   F7Base, 3'b001, OpImm, FMT_RRS),
    r_ent(MN_SRL,    F7Base, 3'b101, OpReg, FMT_RRR),
    r_ent(MN_SRLI,   F7Base, 3'b101, OpImm, FMT_RRS),
    r_ent(MN_SRA,    F7Alt,  3'b101, OpReg, FMT_RRR),
    r_ent(MN_SRAI,   F7Alt,  3'b101, OpImm, FMT_RRS),
    r_ent(MN_MUL,    F7Mul,  3'b000, OpReg, FMT_RRR),
    r_ent(MN_MULH,   F7Mul,  3'b001, OpReg, FMT_RRR),
    r_ent(MN_MULHSU, F7Mul,  3'b010, OpReg, FMT_RRR),
    r_ent(MN_MULHU,  F7Mul,  3'b011, OpReg, FMT_RRR),
    r_ent(MN_DIV,    F7Mul,  3'b100, OpReg, FMT_RRR),
    r_ent(MN_DIVU,   F7Mul,  3'b101, OpReg, FMT_RRR),
    r_ent(MN_REM,    F7Mul,  3'b110, OpReg, FMT_RRR),
    r_ent(MN_REMU,   F7Mul,  3'b111, OpReg, FMT_RRR),
    // atomics
    a_ent(MN_SC_W,       5'b00011),
    a_ent(MN_AMOSWAP_W,  5'b00001),
    a_ent(MN_AMOADD_W,   5'b00000),
    a_ent(MN_AMOXOR_W,   5'b00100),
    a_ent(MN_AMOAND_W,   5'b01100),
    a_ent(MN_AMOOR_W,    5'b01000),
    a_ent(MN_AMOMIN_W,   5'b10000),
    a_ent(MN_AMOMAX_W,   5'b10100),
    a_ent(MN_AMOMINU_W,  5'b11000),
    a_ent(MN_AMOMAXU_W,  5'b11100),
    // funct3 + opcode
    i_ent(MN_ADDI,   3'b000, OpImm,    LAY_I, FMT_RRI),
    i_ent(MN_XORI,   3'b100, OpImm,    LAY_I, FMT_RRI),
    i_ent(MN_ORI,    3'b110, OpImm,    LAY_I, FMT_RRI),
    i_ent(MN_ANDI,   3'b111, OpImm,    LAY_I, FMT_RRI),
    i_ent(MN_SLTI,   3'b010, OpImm,    LAY_I, FMT_RRI),
    i_ent(MN_SLTIU,  3'b011, OpImm,    LAY_I, FMT_RRI),
    i_ent(MN_BEQ,    3'b000, OpBranch, LAY_B, FMT_RRT),
    i_ent(MN_BNE,    3'b001, OpBranch, LAY_B, FMT_RRT),
    i_ent(MN_BLT,    3'b100, OpBranch, LAY_B, FMT_RRT),
    i_ent(MN_BGE,    3'b101, OpBranch, LAY_B, FMT_RRT),
    i_ent(MN_BLTU,   3'b110, OpBranch, LAY_B, FMT_RRT),
    i_ent(MN_BGEU,   3'b111, OpBranch, LAY_B, FMT_RRT),
    i_ent(MN_JALR,   3'b000, OpJalr,   LAY_I, FMT_RBI),
    i_ent(MN_LB,     3'b000, OpLoad,   LAY_I, FMT_RBI),
    i_ent(MN_LH,     3'b001, OpLoad,   LAY_I, FMT_RBI),
    i_ent(MN_LW,     3'b010, OpLoad,   LAY_I, FMT_RBI),
    i_ent(MN_LBU,    3'b100, OpLoad,   LAY_I, FMT_RBI),
    i_ent(MN_LHU,    3'b101, OpLoad,   LAY_I, FMT_RBI),
    i_ent(MN_SB,     3'b000, OpStore,  LAY_S, FMT_RBI),
    i_ent(MN_SH,     3'b001, OpStore,  LAY_S, FMT_RBI),
    i_ent(MN_SW,     3'b010, OpStore,  LAY_S, FMT_RBI),
    i_ent(MN_CSRRW,  3'b001, OpSystem, LAY_I, FMT_CSRR),
    i_ent(MN_CSRRS,  3'b010, OpSystem, LAY_I, FMT_CSRR),
    i_ent(MN_CSRRC,  3'b011, OpSystem, LAY_I, FMT_CSRR),
    i_ent(MN_CSRRWI, 3'b101, OpSystem, LAY_I, FMT_CSRI),
    i_ent(MN_CSRRSI, 3'b110, OpSystem, LAY_I, FMT_CSRI),
    i_ent(MN_CSRRCI, 3'b111, OpSystem, LAY_I, FMT_CSRI),
    // opcode only
    u_ent(MN_LUI,    OpLui,   LAY_U, FMT_RI),
    u_ent(MN_AUIPC,  OpAuipc, LAY_U, FMT_RI),
    u_ent(MN_JAL,    OpJal,   LAY_J, FMT_RT),
    // catch-all
    mk(MN_UNIMP, 32'h00000000, 32'h00000000, LAY_R, FMT_NONE)
  };

endpackage

// File: sv/rvid_match.sv
// Pattern matcher: compares the instruction word against every table entry
// and keeps the most specific hit. Uses rvid_pkg.

module rvid_match (
  input  logic [31:0]     inst_i,
  output rvid_pkg::decode_t dec_o
);

  logic [rvid_pkg::EntryCount-1:0] hit;

  always_comb begin
    for (int r = 0; r < rvid_pkg::EntryCount; r++) begin
      hit[r] = (inst_i & rvid_pkg::DecodeTable[r].pat_mask)
               == rvid_pkg::DecodeTable[r].pat_bits;
    end
  end

  // Table is ranked, so the lowest hit index wins; the last entry always hits.
  always_comb begin
    dec_o = rvid_pkg::DecodeTable[rvid_pkg::EntryCount-1].dec;
    for (int r = rvid_pkg::EntryCount - 2; r >= 0; r--) begin
      if (hit[r]) begin
        dec_o = rvid_pkg::DecodeTable[r].dec;
      end
    end
  end

endmodule

// File: sv/rvid_operand.sv
// Operand extraction: immediate by layout, branch and jump target, atomic
// ordering flags. Uses rvid_pkg.

module rvid_operand (
  input  logic [31:0]       inst_i,
  input  logic [31:0]       pc_i,
  input  rvid_pkg::decode_t dec_i,
  output logic [20:0]       imm_o,
  output logic [31:0]       target_o,
  output logic              aq_o,
  output logic              rl_o
);

  always_comb begin
    case (dec_i.lay)
      rvid_pkg::LAY_I: imm_o = {9'b0, inst_i[31:20]};
      rvid_pkg::LAY_S: imm_o = {9'b0, inst_i[31:25], inst_i[11:7]};
      rvid_pkg::LAY_B: imm_o = {8'b0, inst_i[31], inst_i[7], inst_i[30:25],
                                inst_i[11:8], 1'b0};
      rvid_pkg::LAY_U: imm_o = {1'b0, inst_i[31:12]};
      rvid_pkg::LAY_J: imm_o = {inst_i[31], inst_i[19:12], inst_i[20],
                                inst_i[30:21], 1'b0};
      default:         imm_o = '0;
    endcase
  end

  always_comb begin
    case (dec_i.fmt)
      rvid_pkg::FMT_RT:  target_o = pc_i + {{11{imm_o[20]}}, imm_o};
      rvid_pkg::FMT_RRT: target_o = pc_i + {{19{imm_o[12]}}, imm_o[12:0]};
      default:           target_o = '0;
    endcase
  end

  // aq and rl only mean something for atomics
  always_comb begin
    aq_o = 1'b0;
    rl_o = 1'b0;
    if (dec_i.fmt inside {rvid_pkg::FMT_AMO2, rvid_pkg::FMT_AMO3}) begin
      aq_o = inst_i[26];
      rl_o = inst_i[25];
    end
  end

endmodule

// File: sv/rv32ima_instruction_decoder_top.sv
// Top level of the RV32IMA instruction decoder: input register, decode logic
// and result register. Uses rvid_pkg, rvid_match and rvid_operand.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+-------------------------------------
//   in      | in_valid_i  | in_stall_o   | instruction_i, pc_i
//   out     | out_valid_o | out_stall_i  | mnemonic_o .. release_res_o
//
// One item per cycle unless stalled; items pass input, then result register.
// The path between the two registers is the pattern match and one 32-bit add.
// Reset clears both valid flags; payload registers keep whatever they hold.
// A stall on the output holds a full result register and, once the input
// register is also full, raises in_stall_o in the same cycle.

module rv32ima_instruction_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] instruction_i,
  input  logic [31:0] pc_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  mnemonic_o,
  output logic [3:0]  operand_format_o,
  output logic [4:0]  dest_reg_o,
  output logic [4:0]  src1_reg_o,
  output logic [4:0]  src2_reg_o,
  output logic [20:0] immediate_o,
  output logic [31:0] target_address_o,
  output logic        acquire_o,
  output logic        release_res_o
);

  typedef struct packed {
    logic [6:0]  mnem;
    logic [3:0]  fmt;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [20:0] imm;
    logic [31:0] target;
    logic        aq;
    logic        rl;
  } result_t;

  logic        in_vld_q;
  logic [31:0] inst_q;
  logic [31:0] pc_q;
  logic        out_vld_q;
  result_t     res_q;
  result_t     res_d;

  rvid_pkg::decode_t dec;
  logic [20:0]       imm;
  logic [31:0]       target;
  logic              aq;
  logic              rl;
  logic              out_load;
  logic              in_load;

  // result register takes a new item whenever it is empty or being drained
  assign out_load   = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_load;
  assign in_load    = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_vld_q <= in_valid_i;
      end
      if (out_load) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      inst_q <= instruction_i;
      pc_q   <= pc_i;
    end
    if (out_load && in_vld_q) begin
      res_q <= res_d;
    end
  end

  rvid_match u_match (
    .inst_i (inst_q),
    .dec_o  (dec)
  );

  rvid_operand u_operand (
    .inst_i   (inst_q),
    .pc_i     (pc_q),
    .dec_i    (dec),
    .imm_o    (imm),
    .target_o (target),
    .aq_o     (aq),
    .rl_o     (rl)
  );

  always_comb begin
    res_d.mnem   = dec.mnem;
    res_d.fmt    = dec.fmt;
    res_d.rd     = inst_q[11:7];
    res_d.rs1    = inst_q[19:15];
    res_d.rs2    = inst_q[24:20];
    res_d.imm    = imm;
    res_d.target = target;
    res_d.aq     = aq;
    res_d.rl     = rl;
  end

  assign out_valid_o      = out_vld_q;
  assign mnemonic_o       = res_q.mnem;
  assign operand_format_o = res_q.fmt;
  assign dest_reg_o       = res_q.rd;
  assign src1_reg_o       = res_q.rs1;
  assign src2_reg_o       = res_q.rs2;
  assign immediate_o      = res_q.imm;
  assign target_address_o = res_q.target;
  assign acquire_o        = res_q.aq;
  assign release_res_o    = res_q.rl;

endmodule

// File: sv/rvid_checker.sv
// Port-level checks for the RV32IMA instruction decoder, attached to the top
// level by the bind at the end of this file. Uses rvid_pkg.

module rvid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  mnemonic_o,
  input logic [3:0]  operand_format_o,
  input logic [20:0] immediate_o,
  input logic [31:0] target_address_o,
  input logic        acquire_o,
  input logic        release_res_o
);

  // a stalled item holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mnemonic_o)
      && $stable(target_address_o) && $stable(immediate_o))
    else $error("output item changed under stall");

  // only branches and jal carry a target
  a_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && operand_format_o != rvid_pkg::FMT_RT
      && operand_format_o != rvid_pkg::FMT_RRT |-> target_address_o == '0)
    else $error("target on a non-branch item");

  // ordering flags only on atomics
  a_flags_amo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (acquire_o || release_res_o)
      |-> operand_format_o == rvid_pkg::FMT_AMO2
       || operand_format_o == rvid_pkg::FMT_AMO3)
    else $error("aq/rl set on a non-atomic item");

  // unknown words decode with no format and no immediate
  a_unimp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mnemonic_o == rvid_pkg::MN_UNIMP
      |-> operand_format_o == rvid_pkg::FMT_NONE && immediate_o == '0)
    else $error("unimp with operands");

  // an accepted item with a free output passes both registers to the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted item did not reach the output");

endmodule

bind rv32ima_instruction_decoder_top rvid_checker u_rvid_checker (.*);
